// File: hdl/dcs_pkg.sv
`timescale 1ns / 1ps
package dcs_pkg;

   // Default sizing
   localparam int MAX_POINTS_DEF = 4096;
   localparam int BIN_BITS_DEF   = 16;

   // Field widths
   localparam int COORD_W = 32;
   localparam int DEPTH_W = 32;
   localparam int INDEX_W = 12;
   localparam int CSR_IDX_W = 2;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_COEFF_X = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COEFF_Y = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COEFF_Z = 2'd2;

   // Configuration reset values
   localparam logic signed [COORD_W-1:0] COEFF_X_RST = 32'sd0;
   localparam logic signed [COORD_W-1:0] COEFF_Y_RST = 32'sd0;
   localparam logic signed [COORD_W-1:0] COEFF_Z_RST = 32'sd65536;

   // Request modes
   localparam logic MODE_LOAD = 1'b0;
   localparam logic MODE_READ = 1'b1;

   // Depth extremes
   localparam logic signed [DEPTH_W-1:0] DEPTH_MAX = 32'sh7FFFFFFF;
   localparam logic signed [DEPTH_W-1:0] DEPTH_MIN = 32'sh80000000;

endpackage

// File: hdl/depth_counting_sort.sv
`timescale 1ns / 1ps
// Depth ordering of a point set. A load (req_mode 0) takes one point; its depth
// passes a three-stage multiply/sum/store pipeline and the receiver gets no
// transaction for it. A load with req_last set raises busy and runs the sort over
// the state memories, each with one read and one write port: a clear sweep of all
// 2^BIN_BITS bin counters, then per point a depth read, a bin found by division
// (one divider step per bin bit, skipped when all depths are equal) and a counter
// increment, then a prefix scan over the bins, then a scatter of each point into
// the order. A read (req_mode 1) is accepted every cycle while idle and answers with
// one rsp_valid strobe on the next cycle; the receiver cannot stall, so the result
// must be captured on that strobe.
module depth_counting_sort #(
   parameter int MAX_POINTS = dcs_pkg::MAX_POINTS_DEF,
   parameter int BIN_BITS   = dcs_pkg::BIN_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic                               req_mode,
   input  logic signed [dcs_pkg::COORD_W-1:0] req_pos_x,
   input  logic signed [dcs_pkg::COORD_W-1:0] req_pos_y,
   input  logic signed [dcs_pkg::COORD_W-1:0] req_pos_z,
   input  logic                               req_last,
   output logic                               rsp_valid,
   output logic [dcs_pkg::INDEX_W-1:0]        rsp_point_index,
   output logic                               rsp_final_entry,
   output logic                               rsp_valid_res,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [dcs_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [dcs_pkg::COORD_W-1:0]        csr_data
);

   localparam int IW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int CW = $clog2(MAX_POINTS + 1);
   localparam int NB = 1 << BIN_BITS;
   localparam int SW = $clog2(BIN_BITS + 1);
   localparam int DW = dcs_pkg::DEPTH_W;
   localparam int NW = DW + BIN_BITS;

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_CLR   = 4'd1;
   localparam logic [3:0] ST_CRD   = 4'd2;
   localparam logic [3:0] ST_CINIT = 4'd3;
   localparam logic [3:0] ST_CDIV  = 4'd4;
   localparam logic [3:0] ST_CINC  = 4'd5;
   localparam logic [3:0] ST_CWR   = 4'd6;
   localparam logic [3:0] ST_PRD   = 4'd7;
   localparam logic [3:0] ST_PWR   = 4'd8;
   localparam logic [3:0] ST_SRD   = 4'd9;
   localparam logic [3:0] ST_SBIN  = 4'd10;
   localparam logic [3:0] ST_SWR   = 4'd11;

   // Memories
   logic signed [DW-1:0]       depth_mem [MAX_POINTS];
   logic [BIN_BITS-1:0]        bin_mem   [MAX_POINTS];
   logic [CW-1:0]              cnt_mem   [NB];
   logic [IW-1:0]              order_mem [MAX_POINTS];
   logic signed [DW-1:0]       depth_q;
   logic [BIN_BITS-1:0]        bin_q;
   logic [CW-1:0]              cnt_q;
   logic [IW-1:0]              order_q;

   // Registers
   logic signed [dcs_pkg::COORD_W-1:0] coeff_x_ff, coeff_y_ff, coeff_z_ff;
   logic [3:0]                 state_ff, state_in;
   logic                       pa_v_ff, pa_last_ff, pb_v_ff, pb_last_ff;
   logic signed [63:0]         mx_ff, my_ff, mz_ff;
   logic signed [DW-1:0]       dep_ff;
   logic signed [DW-1:0]       min_ff, min_in, max_ff, max_in;
   logic [CW-1:0]              count_ff, count_in;
   logic [IW-1:0]              rpos_ff, rpos_in;
   logic                       ready_ff, ready_in;
   logic [CW-1:0]              i_ff, i_in;
   logic [BIN_BITS-1:0]        bin_ff, bin_in;
   logic [CW-1:0]              sum_ff, sum_in;
   logic [DW-1:0]              range_ff, range_in;
   logic [DW-1:0]              rem_ff, rem_in;
   logic [BIN_BITS-1:0]        lo_ff, lo_in;
   logic [SW-1:0]              step_ff, step_in;
   logic                       rd_pend_ff, rd_ok_ff, rd_final_ff;

   // Memory port controls
   logic                       dep_we, bin_we, cnt_we, ord_we;
   logic [IW-1:0]              dep_wa, dep_ra, bin_wa, bin_ra, ord_wa;
   logic [BIN_BITS-1:0]        cnt_wa, cnt_ra;
   logic [CW-1:0]              cnt_wd;

   logic                       accept, ld_acc, rd_acc;
   logic signed [65:0]         sum_w, adj_w, tq_w;
   logic signed [DW-1:0]       sat_w;
   logic [DW-1:0]              off_w;
   logic [NW-1:0]              num_w;
   logic [DW:0]                trial_w;
   logic                       ge_w;
   logic [CW-1:0]              i_next;
   logic [IW+dcs_pkg::INDEX_W-1:0] idx_ext;

   assign accept    = start && !busy;
   assign ld_acc    = accept && (req_mode == dcs_pkg::MODE_LOAD);
   assign rd_acc    = accept && (req_mode == dcs_pkg::MODE_READ);
   assign busy      = (state_ff != ST_IDLE) || (pa_v_ff && pa_last_ff) || (pb_v_ff && pb_last_ff);
   assign csr_ready = 1'b1;
   assign i_next    = CW'(i_ff + 1'b1);

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         coeff_x_ff <= dcs_pkg::COEFF_X_RST;
         coeff_y_ff <= dcs_pkg::COEFF_Y_RST;
         coeff_z_ff <= dcs_pkg::COEFF_Z_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            dcs_pkg::CSR_COEFF_X: coeff_x_ff <= csr_data;
            dcs_pkg::CSR_COEFF_Y: coeff_y_ff <= csr_data;
            dcs_pkg::CSR_COEFF_Z: coeff_z_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // Depth pipeline: multiply, then sum, truncate toward zero and saturate
   always_comb begin
      sum_w = 66'(mx_ff) + 66'(my_ff) + 66'(mz_ff);
      adj_w = sum_w[65] ? sum_w + 66'sd1048575 : sum_w;
      tq_w  = adj_w >>> 20;
      if (tq_w[65:DW-1] == {(66-DW+1){1'b0}} || tq_w[65:DW-1] == {(66-DW+1){1'b1}})
         sat_w = tq_w[DW-1:0];
      else if (tq_w[65])
         sat_w = dcs_pkg::DEPTH_MIN;
      else
         sat_w = dcs_pkg::DEPTH_MAX;
   end

   always_ff @(posedge clock) begin
      mx_ff  <= coeff_x_ff * req_pos_x;
      my_ff  <= coeff_y_ff * req_pos_y;
      mz_ff  <= coeff_z_ff * req_pos_z;
      dep_ff <= sat_w;
      pa_last_ff <= req_last;
      pb_last_ff <= pa_last_ff;
   end

   // Divider step and bin numerator
   always_comb begin
      off_w   = DW'(depth_q - min_ff);
      num_w   = {off_w, {BIN_BITS{1'b0}}} - NW'(off_w);
      trial_w = {rem_ff, lo_ff[BIN_BITS-1]};
      ge_w    = trial_w >= {1'b0, range_ff};
   end

   // Sequencer and point state
   always_comb begin
      state_in = state_ff;
      min_in   = min_ff;
      max_in   = max_ff;
      count_in = count_ff;
      rpos_in  = rpos_ff;
      ready_in = ready_ff;
      i_in     = i_ff;
      bin_in   = bin_ff;
      sum_in   = sum_ff;
      range_in = range_ff;
      rem_in   = rem_ff;
      lo_in    = lo_ff;
      step_in  = step_ff;
      dep_we = 1'b0; dep_wa = count_ff[IW-1:0]; dep_ra = i_ff[IW-1:0];
      bin_we = 1'b0; bin_wa = i_ff[IW-1:0];     bin_ra = i_ff[IW-1:0];
      cnt_we = 1'b0; cnt_wa = bin_ff;           cnt_ra = bin_ff; cnt_wd = '0;
      ord_we = 1'b0; ord_wa = cnt_q[IW-1:0];

      // Start a new set on a load after a finished sort
      if (ld_acc && ready_ff) begin
         ready_in = 1'b0;
         count_in = '0;
         rpos_in  = '0;
         min_in   = dcs_pkg::DEPTH_MAX;
         max_in   = dcs_pkg::DEPTH_MIN;
      end

      // Advance the read position
      if (rd_acc && ready_ff) begin
         if ((CW'(rpos_ff) + CW'(1)) >= count_ff)
            rpos_in = '0;
         else
            rpos_in = IW'(rpos_ff + 1'b1);
      end

      // Store a finished depth
      if (pb_v_ff) begin
         if (count_ff < CW'(MAX_POINTS)) begin
            dep_we   = 1'b1;
            count_in = CW'(count_ff + 1'b1);
            if (dep_ff < min_ff) min_in = dep_ff;
            if (dep_ff > max_ff) max_in = dep_ff;
         end
         if (pb_last_ff) begin
            state_in = ST_CLR;
            bin_in   = '0;
         end
      end

      case (state_ff)
         ST_IDLE: ;
         ST_CLR: begin
            cnt_we   = 1'b1;
            range_in = DW'(max_ff - min_ff);
            bin_in   = BIN_BITS'(bin_ff + 1'b1);
            i_in     = '0;
            if (&bin_ff) begin
               sum_in = '0;
               if (count_ff == '0) begin
                  state_in = ST_IDLE;
                  ready_in = 1'b0;
                  rpos_in  = '0;
               end else begin
                  state_in = ST_CRD;
               end
            end
         end
         ST_CRD: state_in = ST_CINIT;
         ST_CINIT: begin
            rem_in  = num_w[NW-1:BIN_BITS];
            lo_in   = num_w[BIN_BITS-1:0];
            step_in = '0;
            if (range_ff == '0) begin
               lo_in    = '0;
               state_in = ST_CINC;
            end else begin
               state_in = ST_CDIV;
            end
         end
         ST_CDIV: begin
            rem_in  = ge_w ? DW'(trial_w - {1'b0, range_ff}) : trial_w[DW-1:0];
            lo_in   = {lo_ff[BIN_BITS-2:0], ge_w};
            step_in = SW'(step_ff + 1'b1);
            if (step_ff == SW'(BIN_BITS - 1)) state_in = ST_CINC;
         end
         ST_CINC: begin
            bin_we   = 1'b1;
            cnt_ra   = lo_ff;
            state_in = ST_CWR;
         end
         ST_CWR: begin
            cnt_we = 1'b1;
            cnt_wa = lo_ff;
            cnt_wd = CW'(cnt_q + 1'b1);
            i_in   = i_next;
            if (i_next >= count_ff) state_in = ST_PRD;
            else                    state_in = ST_CRD;
         end
         ST_PRD: state_in = ST_PWR;
         ST_PWR: begin
            cnt_we = 1'b1;
            cnt_wd = sum_ff;
            sum_in = CW'(sum_ff + cnt_q);
            bin_in = BIN_BITS'(bin_ff + 1'b1);
            if (&bin_ff) begin
               i_in     = '0;
               state_in = ST_SRD;
            end else begin
               state_in = ST_PRD;
            end
         end
         ST_SRD: state_in = ST_SBIN;
         ST_SBIN: begin
            cnt_ra   = bin_q;
            bin_in   = bin_q;
            state_in = ST_SWR;
         end
         ST_SWR: begin
            cnt_we = 1'b1;
            cnt_wd = CW'(cnt_q + 1'b1);
            ord_we = 1'b1;
            i_in   = i_next;
            if (i_next >= count_ff) begin
               state_in = ST_IDLE;
               ready_in = 1'b1;
               rpos_in  = '0;
            end else begin
               state_in = ST_SRD;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         pa_v_ff    <= 1'b0;
         pb_v_ff    <= 1'b0;
         min_ff     <= dcs_pkg::DEPTH_MAX;
         max_ff     <= dcs_pkg::DEPTH_MIN;
         count_ff   <= '0;
         rpos_ff    <= '0;
         ready_ff   <= 1'b0;
         rd_pend_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         pa_v_ff    <= ld_acc;
         pb_v_ff    <= pa_v_ff;
         min_ff     <= min_in;
         max_ff     <= max_in;
         count_ff   <= count_in;
         rpos_ff    <= rpos_in;
         ready_ff   <= ready_in;
         rd_pend_ff <= rd_acc;
      end
   end

   always_ff @(posedge clock) begin
      i_ff        <= i_in;
      bin_ff      <= bin_in;
      sum_ff      <= sum_in;
      range_ff    <= range_in;
      rem_ff      <= rem_in;
      lo_ff       <= lo_in;
      step_ff     <= step_in;
      rd_ok_ff    <= ready_ff;
      rd_final_ff <= ready_ff && ((CW'(rpos_ff) + CW'(1)) >= count_ff);
   end

   // Memory ports
   always_ff @(posedge clock) begin
      if (dep_we) depth_mem[dep_wa] <= dep_ff;
      depth_q <= depth_mem[dep_ra];
   end

   always_ff @(posedge clock) begin
      if (bin_we) bin_mem[bin_wa] <= lo_ff;
      bin_q <= bin_mem[bin_ra];
   end

   always_ff @(posedge clock) begin
      if (cnt_we) cnt_mem[cnt_wa] <= cnt_wd;
      cnt_q <= cnt_mem[cnt_ra];
   end

   always_ff @(posedge clock) begin
      if (ord_we) order_mem[ord_wa] <= i_ff[IW-1:0];
      order_q <= order_mem[rpos_ff];
   end

   // Drive the result transaction
   assign idx_ext         = {{dcs_pkg::INDEX_W{1'b0}}, order_q};
   assign rsp_valid       = rd_pend_ff;
   assign rsp_valid_res   = rd_pend_ff && rd_ok_ff;
   assign rsp_final_entry = rd_pend_ff && rd_ok_ff && rd_final_ff;
   assign rsp_point_index = (rd_pend_ff && rd_ok_ff) ? idx_ext[dcs_pkg::INDEX_W-1:0] : '0;

`ifndef SYNTHESIS
   a_rsp_follows_read: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(rd_acc))
      else $error("result strobe without a read transaction");

   a_busy_on_last: assert property (@(posedge clock) disable iff (reset)
      (ld_acc && req_last) |=> busy)
      else $error("last load did not start the sort");

   a_minmax_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CRD) |-> (min_ff <= max_ff))
      else $error("depth range inverted during sort");

   a_final_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_final_entry |-> rsp_valid_res)
      else $error("final entry flagged without a sorted order");
`endif

endmodule

// File: bench/tb_depth_counting_sort.sv
`timescale 1ns / 1ps
module tb_depth_counting_sort;

   // A small set keeps the full-set case within a short run
   localparam int POINTS    = 256;
   localparam int BINS      = 1 << dcs_pkg::BIN_BITS_DEF;
   localparam int SETTLE    = 8;
   localparam int CYCLE_CAP = 8000000;

   typedef struct {
      logic [dcs_pkg::INDEX_W-1:0] point_index;
      logic                        final_entry;
      logic                        valid_res;
   } order_entry_type;

   // Predicts the sorted order and checks every read transaction against it
   class order_scoreboard;
      logic signed [dcs_pkg::COORD_W-1:0] wx, wy, wz;
      logic signed [dcs_pkg::DEPTH_W-1:0] depth_of [POINTS];
      logic signed [dcs_pkg::DEPTH_W-1:0] lo_depth, hi_depth;
      int unsigned               order_of [POINTS];
      int unsigned               bin_of [POINTS];
      int unsigned               per_bin [BINS];
      int unsigned               n_points, read_pos;
      bit                        have_order;
      order_entry_type           pending [$];
      int                        errors;

      function void clear_set();
         n_points   = 0;
         read_pos   = 0;
         have_order = 0;
         lo_depth   = dcs_pkg::DEPTH_MAX;
         hi_depth   = dcs_pkg::DEPTH_MIN;
      endfunction

      function void reset_state();
         wx = dcs_pkg::COEFF_X_RST;
         wy = dcs_pkg::COEFF_Y_RST;
         wz = dcs_pkg::COEFF_Z_RST;
         errors = 0;
         clear_set();
      endfunction

      function void write_coeff(logic [dcs_pkg::CSR_IDX_W-1:0] idx,
                                logic [dcs_pkg::COORD_W-1:0] val);
         case (idx)
            dcs_pkg::CSR_COEFF_X: wx = val;
            dcs_pkg::CSR_COEFF_Y: wy = val;
            dcs_pkg::CSR_COEFF_Z: wz = val;
            default: ;
         endcase
      endfunction

      // Exact Q32.32 dot product times 4096, truncated toward zero, saturated
      function logic signed [dcs_pkg::DEPTH_W-1:0] depth(
            logic signed [dcs_pkg::COORD_W-1:0] x,
            logic signed [dcs_pkg::COORD_W-1:0] y,
            logic signed [dcs_pkg::COORD_W-1:0] z);
         logic signed [67:0] acc, q;
         acc = longint'(wx) * longint'(x) + longint'(wy) * longint'(y)
             + longint'(wz) * longint'(z);
         q = acc >>> 20;
         if (acc < 0 && acc[19:0] != 0) q = q + 1;
         if (q > 68'sd2147483647) return dcs_pkg::DEPTH_MAX;
         if (q < -68'sd2147483648) return dcs_pkg::DEPTH_MIN;
         return q[dcs_pkg::DEPTH_W-1:0];
      endfunction

      // Bin each depth, then scatter stably by bin
      function void sort_set();
         longint unsigned span, off;
         int unsigned     run, tmp;
         span = longint'(hi_depth) - longint'(lo_depth);
         foreach (per_bin[b]) per_bin[b] = 0;
         for (int i = 0; i < n_points; i++) begin
            bin_of[i] = 0;
            if (span != 0) begin
               off = longint'(depth_of[i]) - longint'(lo_depth);
               bin_of[i] = 32'(((off * (BINS - 1)) / span) & (BINS - 1));
            end
            per_bin[bin_of[i]]++;
         end
         run = 0;
         foreach (per_bin[b]) begin
            tmp = per_bin[b];
            per_bin[b] = run;
            run += tmp;
         end
         for (int i = 0; i < n_points; i++) begin
            order_of[per_bin[bin_of[i]]] = i;
            per_bin[bin_of[i]]++;
         end
         read_pos   = 0;
         have_order = n_points > 0;
      endfunction

      function void note_item(logic mode, logic signed [dcs_pkg::COORD_W-1:0] x,
                              logic signed [dcs_pkg::COORD_W-1:0] y,
                              logic signed [dcs_pkg::COORD_W-1:0] z, logic last);
         order_entry_type e;
         logic signed [dcs_pkg::DEPTH_W-1:0] d;
         if (mode == dcs_pkg::MODE_LOAD) begin
            if (have_order) clear_set();
            if (n_points < POINTS) begin
               d = depth(x, y, z);
               depth_of[n_points] = d;
               if (d < lo_depth) lo_depth = d;
               if (d > hi_depth) hi_depth = d;
               n_points++;
            end
            if (last) sort_set();
            return;
         end
         e = '{point_index: '0, final_entry: 1'b0, valid_res: 1'b0};
         if (have_order && read_pos < n_points) begin
            e.point_index = order_of[read_pos][dcs_pkg::INDEX_W-1:0];
            e.valid_res   = 1'b1;
            if (read_pos + 1 >= n_points) begin
               e.final_entry = 1'b1;
               read_pos = 0;
            end else begin
               read_pos++;
            end
         end
         pending.push_back(e);
      endfunction

      function void check(logic [dcs_pkg::INDEX_W-1:0] idx, logic fin, logic vr);
         order_entry_type e;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result idx=%0d final=%0b valid=%0b",
                     $time, idx, fin, vr);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (idx !== e.point_index) begin
            $display("%0t: point_index expected %0d actual %0d", $time, e.point_index, idx);
            errors++;
         end
         if (fin !== e.final_entry) begin
            $display("%0t: final_entry expected %0b actual %0b", $time, e.final_entry, fin);
            errors++;
         end
         if (vr !== e.valid_res) begin
            $display("%0t: valid_res expected %0b actual %0b", $time, e.valid_res, vr);
            errors++;
         end
      endfunction
   endclass

   logic                               clock, reset, start, busy;
   logic                               req_mode, req_last;
   logic signed [dcs_pkg::COORD_W-1:0] req_pos_x, req_pos_y, req_pos_z;
   logic                               rsp_valid, rsp_final_entry, rsp_valid_res;
   logic [dcs_pkg::INDEX_W-1:0]        rsp_point_index;
   logic                               csr_valid, csr_ready;
   logic [dcs_pkg::CSR_IDX_W-1:0]      csr_index;
   logic [dcs_pkg::COORD_W-1:0]        csr_data;

   order_scoreboard sb;
   int              gap_pct;
   int unsigned     cycles = 0;

   depth_counting_sort #(.MAX_POINTS(POINTS)) dut (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_CAP) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Capture each response strobe
   always @(posedge clock) begin
      if (!reset && rsp_valid) sb.check(rsp_point_index, rsp_final_entry, rsp_valid_res);
   end

   task automatic send_item(logic mode, logic signed [dcs_pkg::COORD_W-1:0] x,
                            logic signed [dcs_pkg::COORD_W-1:0] y,
                            logic signed [dcs_pkg::COORD_W-1:0] z, logic last);
      req_mode  <= mode;
      req_pos_x <= x;
      req_pos_y <= y;
      req_pos_z <= z;
      req_last  <= last;
      start     <= 1'b1;
      do @(posedge clock); while (busy);
      sb.note_item(mode, x, y, z, last);
      if ($urandom_range(0, 99) < gap_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   task automatic read_next();
      send_item(dcs_pkg::MODE_READ, $urandom, $urandom, $urandom,
                1'($urandom_range(0, 1)));
   endtask

   // Hold off until all results are in and the block has gone quiet
   task automatic wait_quiet();
      start <= 1'b0;
      @(posedge clock);
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic write_csr(logic [dcs_pkg::CSR_IDX_W-1:0] idx,
                            logic [dcs_pkg::COORD_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      sb.write_coeff(idx, val);
   endtask

   task automatic set_coeffs(logic [dcs_pkg::COORD_W-1:0] cx, logic [dcs_pkg::COORD_W-1:0] cy,
                             logic [dcs_pkg::COORD_W-1:0] cz);
      wait_quiet();
      write_csr(dcs_pkg::CSR_COEFF_X, cx);
      write_csr(dcs_pkg::CSR_COEFF_Y, cy);
      write_csr(dcs_pkg::CSR_COEFF_Z, cz);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [dcs_pkg::COORD_W-1:0] pick_value();
      case ($urandom_range(0, 4))
         0, 1: return $urandom;
         2: return $urandom_range(0, 1 << 21) - (1 << 20);
         3: return $urandom_range(0, 1) ? dcs_pkg::DEPTH_MAX : dcs_pkg::DEPTH_MIN;
         default: return $urandom_range(0, 1 << 17) - (1 << 16);
      endcase
   endfunction

   // Load a set with random points, sprinkle stray reads, then walk the order
   task automatic random_set(int n, int extra_reads);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 99) < 4) read_next();
         send_item(dcs_pkg::MODE_LOAD, pick_value(), pick_value(), pick_value(), i == n - 1);
      end
      repeat (n + extra_reads) read_next();
   endtask

   initial begin
      sb = new();
      sb.reset_state();
      gap_pct   = 0;
      reset     = 1'b1;
      start     = 1'b0;
      req_mode  = dcs_pkg::MODE_LOAD;
      req_pos_x = '0;
      req_pos_y = '0;
      req_pos_z = '0;
      req_last  = 1'b0;
      csr_valid = 1'b0;
      csr_index = dcs_pkg::CSR_COEFF_X;
      csr_data  = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reads before any order exists
      read_next();
      read_next();
      // Reset weights: depth follows z; extremes and zero, then read past the end
      send_item(dcs_pkg::MODE_LOAD, 32'h7FFFFFFF, 32'h80000000, dcs_pkg::DEPTH_MAX, 1'b0);
      send_item(dcs_pkg::MODE_LOAD, 32'h80000000, 32'h7FFFFFFF, dcs_pkg::DEPTH_MIN, 1'b0);
      send_item(dcs_pkg::MODE_LOAD, 0, 0, 0, 1'b0);
      send_item(dcs_pkg::MODE_LOAD, 0, 0, 32'sd65536, 1'b1);
      repeat (6) read_next();
      // Equal depths put every point in bin zero
      send_item(dcs_pkg::MODE_LOAD, 5, 6, 32'sd4096, 1'b0);
      send_item(dcs_pkg::MODE_LOAD, -5, 9, 32'sd4096, 1'b1);
      repeat (3) read_next();
      // Load after a sort drops the order until the next last
      send_item(dcs_pkg::MODE_LOAD, 1, 2, 3, 1'b0);
      read_next();
      // Most negative weights saturate both ways
      set_coeffs(32'h80000000, 32'h80000000, 32'h80000000);
      send_item(dcs_pkg::MODE_LOAD, dcs_pkg::DEPTH_MIN, dcs_pkg::DEPTH_MIN,
                dcs_pkg::DEPTH_MIN, 1'b0);
      send_item(dcs_pkg::MODE_LOAD, dcs_pkg::DEPTH_MAX, dcs_pkg::DEPTH_MAX,
                dcs_pkg::DEPTH_MAX, 1'b1);
      repeat (3) read_next();

      // Random sets over idling phases and weight settings
      for (int s = 0; s < 3; s++) begin
         gap_pct = (s == 0) ? 0 : (s == 1) ? 55 : 16;
         if (s == 1) set_coeffs(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
         else set_coeffs(pick_value(), pick_value(), pick_value());
         random_set((s == 0) ? 200 : (s == 1) ? 140 : 25, $urandom_range(1, 4));
      end

      // Overfill the set; the extra load with last still sorts what was stored
      gap_pct = 0;
      set_coeffs($urandom_range(0, 1 << 17) - (1 << 16), $urandom, 32'sd65536);
      for (int i = 0; i <= POINTS; i++)
         send_item(dcs_pkg::MODE_LOAD, pick_value(), pick_value(), pick_value(),
                   i == POINTS);
      repeat (20) read_next();

      wait_quiet();
      repeat (20) @(posedge clock);
      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
